// File: hw/rtl/jsmv_pkg.sv
package jsmv_pkg;

    typedef enum logic [3:0] {
        P_OPEN1   = 4'd0,
        P_KWQUOTE = 4'd1,
        P_KEYWORD = 4'd2,
        P_COLON1  = 4'd3,
        P_OPEN2   = 4'd4,
        P_QUOTE   = 4'd5,
        P_STRING  = 4'd6,
        P_COLON2  = 4'd7,
        P_NEXT    = 4'd8,
        P_CLOSE   = 4'd9,
        P_DONE    = 4'd10
    } phase_t;

    typedef enum logic [1:0] {
        ST_DATA    = 2'd0,
        ST_ACCEPT  = 2'd1,
        ST_INVALID = 2'd2,
        ST_UNICODE = 2'd3
    } status_t;

    localparam logic [2:0] KW_LEN = 3'd5;
    localparam logic [2:0] KW_BAD = 3'd7;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       in_value;
        logic       string_end;
        status_t    status;
    } out_item_t;

    typedef struct packed {
        phase_t     phase;
        logic [2:0] keyword_index;
        logic       escape_pending;
        logic       string_nonempty;
        logic       value_side;
        logic       error_latched;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:           P_OPEN1,
        keyword_index:   3'd0,
        escape_pending:  1'b0,
        string_nonempty: 1'b0,
        value_side:      1'b0,
        error_latched:   1'b0
    };

    typedef struct packed {
        logic       ok;
        logic       unicode;
        logic [7:0] ch;
    } escape_t;

endpackage

// File: hw/rtl/jsmv_step.sv
module jsmv_step (
    input  jsmv_pkg::parse_state_t state_cur,
    input  jsmv_pkg::in_item_t     item,
    output jsmv_pkg::parse_state_t state_nxt,
    output logic                   res_valid,
    output jsmv_pkg::out_item_t    res_item
);
    import jsmv_pkg::*;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == 8'h20) || (b == 8'h0A) || (b == 8'h0D) || (b == 8'h09);
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] idx);
        case (idx)
            3'd0:    kw_char = 8'h74;
            3'd1:    kw_char = 8'h65;
            3'd2:    kw_char = 8'h78;
            3'd3:    kw_char = 8'h74;
            3'd4:    kw_char = 8'h73;
            default: kw_char = 8'h00;
        endcase
    endfunction

    function automatic escape_t decode_escape(input logic [7:0] b);
        escape_t e;
        e = '{ok: 1'b1, unicode: 1'b0, ch: 8'h00};
        case (b)
            8'h22:   e.ch = 8'h22;
            8'h5C:   e.ch = 8'h5C;
            8'h2F:   e.ch = 8'h2F;
            8'h6E:   e.ch = 8'h0A;
            8'h74:   e.ch = 8'h09;
            8'h72:   e.ch = 8'h0D;
            8'h62:   e.ch = 8'h08;
            8'h66:   e.ch = 8'h0C;
            8'h75: begin
                e.ok      = 1'b0;
                e.unicode = 1'b1;
            end
            default: e.ok = 1'b0;
        endcase
        return e;
    endfunction

    logic       [7:0] b;
    logic             err;
    status_t          err_code;
    logic             have;
    logic             endm;
    logic       [7:0] ch;
    escape_t          esc;
    parse_state_t     st;

    assign b   = item.data_byte;
    assign esc = decode_escape(b);

    always_comb begin
        st       = state_cur;
        err      = 1'b0;
        err_code = ST_INVALID;
        have     = 1'b0;
        endm     = 1'b0;
        ch       = 8'h00;
        case (state_cur.phase)
            P_OPEN1, P_OPEN2, P_KWQUOTE, P_COLON1, P_QUOTE, P_COLON2, P_NEXT, P_CLOSE,
            P_DONE: begin
                if (!is_space(b)) begin
                    if (state_cur.phase == P_OPEN1 && b == 8'h7B) begin
                        st.phase = P_KWQUOTE;
                    end else if (state_cur.phase == P_KWQUOTE && b == 8'h22) begin
                        st.phase          = P_KEYWORD;
                        st.keyword_index  = 3'd0;
                        st.escape_pending = 1'b0;
                    end else if (state_cur.phase == P_COLON1 && b == 8'h3A) begin
                        st.phase = P_OPEN2;
                    end else if (state_cur.phase == P_OPEN2 && b == 8'h7B) begin
                        st.phase      = P_QUOTE;
                        st.value_side = 1'b0;
                    end else if (state_cur.phase == P_QUOTE && b == 8'h22) begin
                        st.phase           = P_STRING;
                        st.string_nonempty = 1'b0;
                        st.escape_pending  = 1'b0;
                    end else if (state_cur.phase == P_COLON2 && b == 8'h3A) begin
                        st.phase      = P_QUOTE;
                        st.value_side = 1'b1;
                    end else if (state_cur.phase == P_NEXT && b == 8'h2C) begin
                        st.phase      = P_QUOTE;
                        st.value_side = 1'b0;
                    end else if (state_cur.phase == P_NEXT && b == 8'h7D) begin
                        st.phase = P_CLOSE;
                    end else if (state_cur.phase == P_CLOSE && b == 8'h7D) begin
                        st.phase = P_DONE;
                    end else begin
                        err = 1'b1;
                    end
                end
            end
            P_KEYWORD: begin
                if (state_cur.escape_pending) begin
                    st.escape_pending = 1'b0;
                    if (esc.unicode) begin
                        err      = 1'b1;
                        err_code = ST_UNICODE;
                    end else if (!esc.ok) begin
                        err = 1'b1;
                    end else begin
                        st.keyword_index = KW_BAD;
                    end
                end else if (b == 8'h22) begin
                    if (state_cur.keyword_index == KW_LEN) begin
                        st.phase = P_COLON1;
                    end else begin
                        err = 1'b1;
                    end
                end else if (b == 8'h5C) begin
                    st.escape_pending = 1'b1;
                end else if (b < CTRL_LIMIT) begin
                    err = 1'b1;
                end else if (state_cur.keyword_index < KW_LEN
                             && kw_char(state_cur.keyword_index) == b) begin
                    st.keyword_index = state_cur.keyword_index + 3'd1;
                end else begin
                    st.keyword_index = KW_BAD;
                end
            end
            P_STRING: begin
                if (state_cur.escape_pending) begin
                    st.escape_pending = 1'b0;
                    if (esc.unicode) begin
                        err      = 1'b1;
                        err_code = ST_UNICODE;
                    end else if (!esc.ok) begin
                        err = 1'b1;
                    end else begin
                        have               = 1'b1;
                        ch                 = esc.ch;
                        st.string_nonempty = 1'b1;
                    end
                end else if (b == 8'h22) begin
                    if (!state_cur.value_side) begin
                        st.keyword_index = {2'b00, state_cur.string_nonempty};
                        st.phase         = P_COLON2;
                        have             = 1'b1;
                        endm             = 1'b1;
                    end else if (state_cur.keyword_index != 3'd0
                                 && state_cur.string_nonempty) begin
                        st.phase = P_NEXT;
                        have     = 1'b1;
                        endm     = 1'b1;
                    end else begin
                        err = 1'b1;
                    end
                end else if (b == 8'h5C) begin
                    st.escape_pending = 1'b1;
                end else if (b < CTRL_LIMIT) begin
                    err = 1'b1;
                end else begin
                    have               = 1'b1;
                    ch                 = b;
                    st.string_nonempty = 1'b1;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    always_comb begin
        state_nxt = st;
        res_valid = 1'b0;
        res_item  = '{out_char: 8'h00, in_value: 1'b0, string_end: 1'b0, status: ST_DATA};
        if (state_cur.error_latched) begin
            if (item.last) begin
                state_nxt = STATE_RESET;
            end else begin
                state_nxt = state_cur;
            end
        end else if (err) begin
            res_valid       = 1'b1;
            res_item.status = err_code;
            if (item.last) begin
                state_nxt = STATE_RESET;
            end else begin
                state_nxt.error_latched = 1'b1;
            end
        end else if (item.last) begin
            res_valid       = 1'b1;
            res_item.status = (st.phase == P_DONE) ? ST_ACCEPT : ST_INVALID;
            state_nxt       = STATE_RESET;
        end else if (have) begin
            res_valid           = 1'b1;
            res_item.out_char   = ch;
            res_item.in_value   = st.value_side;
            res_item.string_end = endm;
        end
    end

endmodule

// File: hw/rtl/json_string_map_validator.sv
// Byte-serial checker and decoder for files of the form {"texts":{"key":"value",...}}.
// The input channel (s_valid, s_ready, s_item) takes one raw byte of the file per item,
// with last set on the final byte. The result channel (m_valid, m_ready, m_item) gives
// at most one item per input item: a decoded key or value character, an end-of-string
// mark, the file-accepted status on the last byte, or an error status.
// Throughput is one byte per cycle while s_ready is high: the parser state update and
// result selection are one combinational step between the state registers and the
// output register, from which each result appears on m_item.
// When the receiver stalls, one further result is held in a skid register, so s_ready
// is a register output and drops only when both the output and skid registers are full.
// Bytes that give no result never need output space but still wait for s_ready.
// After an error the block ignores bytes up to and including the one marked last.
// After reset, and after every last byte, the parser expects the opening brace of a
// new file; after reset both result registers are also empty.
module json_string_map_validator (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jsmv_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output jsmv_pkg::out_item_t m_item
);
    import jsmv_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_item_t    out_item_reg;
    out_item_t    out_item_next;
    logic         skid_valid_reg;
    logic         skid_valid_next;
    out_item_t    skid_item_reg;
    out_item_t    skid_item_next;

    parse_state_t step_state;
    logic         step_valid;
    out_item_t    step_item;
    logic         accept;
    logic         take;
    logic         new_res;

    jsmv_step u_step (
        .state_cur (state_reg),
        .item      (s_item),
        .state_nxt (step_state),
        .res_valid (step_valid),
        .res_item  (step_item)
    );

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;
    assign accept  = s_valid && s_ready;
    assign take    = out_valid_reg && m_ready;
    assign new_res = accept && step_valid;

    always_comb begin
        state_next      = accept ? step_state : state_reg;
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = new_res;
                out_item_next  = step_item;
            end
        end else if (!out_valid_reg) begin
            out_valid_next = new_res;
            out_item_next  = step_item;
        end else if (new_res) begin
            skid_valid_next = 1'b1;
            skid_item_next  = step_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= STATE_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds an item while the output register is empty.");

    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.last)
        |=> (state_reg.phase == P_OPEN1 && !state_reg.error_latched))
        else $error("Parser did not return to its start state after the last byte.");

    a_status_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.status != ST_DATA)
        |-> (m_item.out_char == 8'h00 && !m_item.string_end && !m_item.in_value))
        else $error("A status item carries character or mark bits.");

    a_latched_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && state_reg.error_latched && !skid_valid_reg && !out_valid_reg)
        |=> !m_valid)
        else $error("A byte after a reported error produced an item.");

endmodule

// File: tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jsmv_pkg::*;

    localparam int ITEM_TARGET = 1100;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 10;
    localparam logic [39:0] KEYWORD_TEXT = "texts";

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       fixed;
        logic       fixed_has;
        status_t    fixed_status;
    } dir_row_t;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    logic    row_fixed = 1'b0;
    logic    row_fixed_has = 1'b0;
    status_t row_fixed_status = ST_DATA;

    parse_state_t ps = STATE_RESET;
    out_item_t    decode_q[$];
    logic [7:0]   file_bytes[$];
    int           sent = 0;
    int           mismatches = 0;
    int           stall_cycles = 0;

    // A complete file with an escaped quote and a 0xFF character, then short broken files.
    dir_row_t directed_rows [25] = '{
        '{"{",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\"",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{"t",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"e",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"x",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"t",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"s",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\"",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{":",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"{",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\"",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{"a",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\\",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\"",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\"",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{":",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\"",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{8'hFF, 1'b0, 1'b0, 1'b0, ST_DATA},
        '{"\"",  1'b0, 1'b0, 1'b0, ST_DATA},
        '{"}",   1'b0, 1'b0, 1'b0, ST_DATA},
        '{"}",   1'b1, 1'b1, 1'b1, ST_ACCEPT},
        '{8'h00, 1'b1, 1'b1, 1'b1, ST_INVALID},
        '{"{",   1'b1, 1'b1, 1'b1, ST_INVALID},
        '{"}",   1'b0, 1'b1, 1'b1, ST_INVALID},
        '{8'hFF, 1'b1, 1'b1, 1'b0, ST_DATA}
    };

    json_string_map_validator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic bit is_blank(input logic [7:0] b);
        return b == " " || b == 8'h0A || b == 8'h0D || b == 8'h09;
    endfunction

    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        return KEYWORD_TEXT[8 * (4 - idx) +: 8];
    endfunction

    function automatic escape_t resolve_escape(input logic [7:0] b);
        escape_t e;
        e.ok = 1'b1;
        e.unicode = 1'b0;
        e.ch = b;
        case (b)
            "\"", "\\", "/": ;
            "n": e.ch = 8'h0A;
            "t": e.ch = 8'h09;
            "r": e.ch = 8'h0D;
            "b": e.ch = 8'h08;
            "f": e.ch = 8'h0C;
            "u": begin
                e.ok = 1'b0;
                e.unicode = 1'b1;
            end
            default: e.ok = 1'b0;
        endcase
        return e;
    endfunction

    task automatic decode_byte(input in_item_t it, output bit got, output out_item_t res);
        logic [7:0] b;
        logic [7:0] ch;
        status_t    err;
        bit         have;
        bit         endm;
        escape_t    e;
        b = it.data_byte;
        ch = 8'h00;
        err = ST_DATA;
        have = 1'b0;
        endm = 1'b0;
        got = 1'b0;
        res.out_char = 8'h00;
        res.in_value = 1'b0;
        res.string_end = 1'b0;
        res.status = ST_DATA;
        if (ps.error_latched) begin
            if (it.last)
                ps = STATE_RESET;
            return;
        end
        case (ps.phase)
            P_OPEN1, P_KWQUOTE, P_COLON1, P_OPEN2, P_QUOTE, P_COLON2, P_NEXT, P_CLOSE,
            P_DONE: begin
                if (!is_blank(b)) begin
                    if (ps.phase == P_OPEN1 && b == "{") begin
                        ps.phase = P_KWQUOTE;
                    end else if (ps.phase == P_KWQUOTE && b == "\"") begin
                        ps.phase = P_KEYWORD;
                        ps.keyword_index = 3'd0;
                        ps.escape_pending = 1'b0;
                    end else if (ps.phase == P_COLON1 && b == ":") begin
                        ps.phase = P_OPEN2;
                    end else if (ps.phase == P_OPEN2 && b == "{") begin
                        ps.phase = P_QUOTE;
                        ps.value_side = 1'b0;
                    end else if (ps.phase == P_QUOTE && b == "\"") begin
                        ps.phase = P_STRING;
                        ps.string_nonempty = 1'b0;
                        ps.escape_pending = 1'b0;
                    end else if (ps.phase == P_COLON2 && b == ":") begin
                        ps.phase = P_QUOTE;
                        ps.value_side = 1'b1;
                    end else if (ps.phase == P_NEXT && b == ",") begin
                        ps.phase = P_QUOTE;
                        ps.value_side = 1'b0;
                    end else if (ps.phase == P_NEXT && b == "}") begin
                        ps.phase = P_CLOSE;
                    end else if (ps.phase == P_CLOSE && b == "}") begin
                        ps.phase = P_DONE;
                    end else begin
                        err = ST_INVALID;
                    end
                end
            end
            P_KEYWORD: begin
                if (ps.escape_pending) begin
                    ps.escape_pending = 1'b0;
                    e = resolve_escape(b);
                    if (e.unicode)
                        err = ST_UNICODE;
                    else if (!e.ok)
                        err = ST_INVALID;
                    else
                        ps.keyword_index = KW_BAD;
                end else if (b == "\"") begin
                    if (ps.keyword_index == KW_LEN)
                        ps.phase = P_COLON1;
                    else
                        err = ST_INVALID;
                end else if (b == "\\") begin
                    ps.escape_pending = 1'b1;
                end else if (b < CTRL_LIMIT) begin
                    err = ST_INVALID;
                end else if (ps.keyword_index < KW_LEN
                             && keyword_char(ps.keyword_index) == b) begin
                    ps.keyword_index = ps.keyword_index + 3'd1;
                end else begin
                    ps.keyword_index = KW_BAD;
                end
            end
            P_STRING: begin
                if (ps.escape_pending) begin
                    ps.escape_pending = 1'b0;
                    e = resolve_escape(b);
                    if (e.unicode) begin
                        err = ST_UNICODE;
                    end else if (!e.ok) begin
                        err = ST_INVALID;
                    end else begin
                        have = 1'b1;
                        ch = e.ch;
                        ps.string_nonempty = 1'b1;
                    end
                end else if (b == "\"") begin
                    if (!ps.value_side) begin
                        ps.keyword_index = ps.string_nonempty ? 3'd1 : 3'd0;
                        ps.phase = P_COLON2;
                        have = 1'b1;
                        endm = 1'b1;
                    end else if (ps.keyword_index != 3'd0 && ps.string_nonempty) begin
                        ps.phase = P_NEXT;
                        have = 1'b1;
                        endm = 1'b1;
                    end else begin
                        err = ST_INVALID;
                    end
                end else if (b == "\\") begin
                    ps.escape_pending = 1'b1;
                end else if (b < CTRL_LIMIT) begin
                    err = ST_INVALID;
                end else begin
                    have = 1'b1;
                    ch = b;
                    ps.string_nonempty = 1'b1;
                end
            end
            default: err = ST_INVALID;
        endcase

        if (err != ST_DATA) begin
            got = 1'b1;
            res.status = err;
            if (it.last)
                ps = STATE_RESET;
            else
                ps.error_latched = 1'b1;
        end else if (it.last) begin
            got = 1'b1;
            res.status = (ps.phase == P_DONE) ? ST_ACCEPT : ST_INVALID;
            ps = STATE_RESET;
        end else if (have) begin
            got = 1'b1;
            res.out_char = ch;
            res.in_value = ps.value_side;
            res.string_end = endm;
        end
    endtask

    task automatic add_blanks();
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (n) begin
            case ($urandom_range(3))
                0: file_bytes.push_back(" ");
                1: file_bytes.push_back(8'h09);
                2: file_bytes.push_back(8'h0D);
                default: file_bytes.push_back(8'h0A);
            endcase
        end
    endtask

    task automatic add_text();
        int         len;
        int         r;
        logic [7:0] c;
        len = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 6);
        file_bytes.push_back("\"");
        repeat (len) begin
            r = $urandom_range(99);
            if (r < 75) begin
                c = 8'($urandom_range(8'h20, 8'hFF));
                if (c == "\"" || c == "\\")
                    c = "_";
                file_bytes.push_back(c);
            end else if (r < 97) begin
                file_bytes.push_back("\\");
                case ($urandom_range(7))
                    0: file_bytes.push_back("\"");
                    1: file_bytes.push_back("\\");
                    2: file_bytes.push_back("/");
                    3: file_bytes.push_back("n");
                    4: file_bytes.push_back("t");
                    5: file_bytes.push_back("r");
                    6: file_bytes.push_back("b");
                    default: file_bytes.push_back("f");
                endcase
            end else if (r < 98) begin
                file_bytes.push_back("\\");
                file_bytes.push_back("u");
            end else if (r < 99) begin
                file_bytes.push_back("\\");
                file_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                file_bytes.push_back(8'($urandom_range(0, 8'h1F)));
            end
        end
        file_bytes.push_back("\"");
    endtask

    task automatic compose_file();
        int pairs;
        int r;
        int keep;
        file_bytes.delete();
        add_blanks();
        file_bytes.push_back("{");
        add_blanks();
        if ($urandom_range(9) == 0) begin
            add_text();
        end else begin
            file_bytes.push_back("\"");
            for (int i = 0; i < 5; i++)
                file_bytes.push_back(keyword_char(3'(i)));
            file_bytes.push_back("\"");
        end
        add_blanks();
        file_bytes.push_back(":");
        add_blanks();
        file_bytes.push_back("{");
        pairs = ($urandom_range(29) == 0) ? 0 : $urandom_range(1, 4);
        for (int p = 0; p < pairs; p++) begin
            add_blanks();
            add_text();
            add_blanks();
            file_bytes.push_back(":");
            add_blanks();
            add_text();
            add_blanks();
            if (p < pairs - 1)
                file_bytes.push_back(",");
        end
        file_bytes.push_back("}");
        add_blanks();
        file_bytes.push_back("}");
        add_blanks();
        if ($urandom_range(49) == 0)
            file_bytes.push_back(8'($urandom_range(0, 255)));

        r = $urandom_range(99);
        if (r < 6) begin
            keep = $urandom_range(1, file_bytes.size());
            while (file_bytes.size() > keep)
                void'(file_bytes.pop_back());
        end else if (r < 12) begin
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 15) begin
            file_bytes.delete();
            repeat ($urandom_range(1, 8))
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst, input logic fx,
                             input logic fx_has, input status_t fx_status);
        while (!(sent >= 400 && sent < 700) && $urandom_range(99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item.data_byte <= b;
        s_item.last <= lst;
        row_fixed <= fx;
        row_fixed_has <= fx_has;
        row_fixed_status <= fx_status;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
    endtask

    always @(posedge aclk) begin
        bit        got;
        out_item_t res;
        out_item_t want;
        if (aresetn && s_valid && s_ready) begin
            decode_byte(s_item, got, res);
            if (row_fixed) begin
                got = row_fixed_has;
                res.out_char = 8'h00;
                res.in_value = 1'b0;
                res.string_end = 1'b0;
                res.status = row_fixed_status;
            end
            if (got)
                decode_q.push_back(res);
        end
        if (aresetn && m_valid && m_ready) begin
            if (decode_q.size() == 0) begin
                $display({"%0t: unexpected item: expected none, ",
                          "got char %02h value %0b end %0b status %0d"},
                         $time, m_item.out_char, m_item.in_value, m_item.string_end,
                         m_item.status);
                mismatches++;
            end else begin
                want = decode_q.pop_front();
                if (m_item.out_char !== want.out_char || m_item.in_value !== want.in_value ||
                    m_item.string_end !== want.string_end || m_item.status !== want.status) begin
                    $display({"%0t: item mismatch: ",
                              "expected char %02h value %0b end %0b status %0d, ",
                              "got char %02h value %0b end %0b status %0d"},
                             $time, want.out_char, want.in_value, want.string_end,
                             want.status, m_item.out_char, m_item.in_value,
                             m_item.string_end, m_item.status);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The receiver holds off twice for a long stretch so that the block backs up.
    initial begin
        int rx_cycle;
        rx_cycle = 0;
        forever begin
            @(posedge aclk);
            rx_cycle++;
            if (rx_cycle == 300 || rx_cycle == 1100) begin
                m_ready <= 1'b0;
                repeat (80) @(posedge aclk);
            end else begin
                m_ready <= (rx_cycle >= 600 && rx_cycle < 900) || ($urandom_range(99) >= 10);
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].fixed,
                      directed_rows[i].fixed_has, directed_rows[i].fixed_status);
        while (sent < ITEM_TARGET) begin
            compose_file();
            foreach (file_bytes[i])
                send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, 1'b0, ST_DATA);
        end
        s_valid <= 1'b0;
        while (decode_q.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/jsmv_pkg.sv
hw/rtl/jsmv_step.sv
hw/rtl/json_string_map_validator.sv
tb/testbench.sv
